// ===== hdl/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared constants for the point to polyline squared distance block.
// ----------------------------------------------------------------------------
package ppd_pkg;

	localparam int SEGMENTS_DEF   = 8;
	localparam int COORD_BITS_DEF = 24;

	localparam int SEG_INDEX_BITS = 3;
	localparam int COUNT_BITS     = 4;
	localparam int RADIUS_BITS    = 16;
	localparam int DIST_BITS      = 63;
	localparam int APB_ADDR_BITS  = 3;
	localparam int APB_DATA_BITS  = 32;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// register select, taken from paddr[2]
	localparam logic REG_SEGMENT_COUNT = 1'b0;
	localparam logic REG_RADIUS_SQ     = 1'b1;

	localparam logic [COUNT_BITS-1:0]  COUNT_RESET  = 4'd8;
	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 16'd16;

endpackage

// ===== hdl/point_polyline_distance_sq.sv =====
// ----------------------------------------------------------------------------
// point_polyline_distance_sq
// Segment table in a synchronous memory; a query walks the active segments
// and returns the minimum squared distance and an inside flag.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       into       in_valid / in_stall    action, seg_index, start_*, end_*, point_*
// out      out of     out_valid / out_stall  min_dist_sq, inside_res
// cfg      into       APB psel/penable       segment_count @0, radius_sq @4
//
// A load leaves the input free for the next word. A query visits the n active
// segments in turn; where the closest point is an end point the multiplier and
// the bit-serial divider in ppd_seg_unit are skipped, otherwise both run.
// Reset clears control and registers; the segment table is not cleared.
// A result waiting under out_stall lets the next word in; a query that then
// finishes holds until the output register is free.
// ----------------------------------------------------------------------------
module point_polyline_distance_sq #(
	parameter int SEGMENTS   = ppd_pkg::SEGMENTS_DEF,
	parameter int COORD_BITS = ppd_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic [ppd_pkg::SEG_INDEX_BITS-1:0]   seg_index,
	input  logic signed [COORD_BITS-1:0]         start_x,
	input  logic signed [COORD_BITS-1:0]         start_y,
	input  logic signed [COORD_BITS-1:0]         start_z,
	input  logic signed [COORD_BITS-1:0]         end_x,
	input  logic signed [COORD_BITS-1:0]         end_y,
	input  logic signed [COORD_BITS-1:0]         end_z,
	input  logic signed [COORD_BITS-1:0]         point_x,
	input  logic signed [COORD_BITS-1:0]         point_y,
	input  logic signed [COORD_BITS-1:0]         point_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [ppd_pkg::DIST_BITS-1:0]        min_dist_sq,
	output logic                                 inside_res,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ppd_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [ppd_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [ppd_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                 pready
);
	import ppd_pkg::*;

	localparam int C    = COORD_BITS;
	localparam int IW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int CW   = $clog2(SEGMENTS + 1);
	localparam int DW   = 2*C + 3;
	localparam int XW   = (DW > DIST_BITS) ? DW : DIST_BITS + 1;
	localparam int SLOT = 6*C;

	typedef enum logic [4:0] {
		T_IDLE  = 5'b00001,
		T_READ  = 5'b00010,
		T_START = 5'b00100,
		T_WAIT  = 5'b01000,
		T_DONE  = 5'b10000
	} tstate_t;

	tstate_t                 state_q;
	logic [COUNT_BITS-1:0]   seg_count_q;
	logic [RADIUS_BITS-1:0]  radius_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           n_q;
	logic                    first_q;
	logic [DW-1:0]           best_q;
	logic                    out_valid_q;
	logic [DIST_BITS-1:0]    min_q;
	logic                    inside_q;
	logic [3*C-1:0]          point_q;
	logic [SLOT-1:0]         rd_q;
	logic [SLOT-1:0]         mem [SEGMENTS];

	logic                    accept, load_ok, query_ok, cfg_wr, out_free;
	logic [CW-1:0]           n_eff;
	logic                    seg_done;
	logic [DW-1:0]           seg_dist;
	logic [XW-1:0]           best_x;
	logic [DIST_BITS-1:0]    best_sat;

	assign in_stall = (state_q != T_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load_ok  = accept && (action == ACT_LOAD) && (32'(seg_index) < SEGMENTS);
	assign query_ok = accept && (action == ACT_QUERY);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !out_valid_q || !out_stall;
	assign n_eff    = (32'(seg_count_q) > SEGMENTS) ? CW'(SEGMENTS) : CW'(seg_count_q);

	assign best_x   = XW'(best_q);
	assign best_sat = (|best_x[XW-1:DIST_BITS]) ? '1 : best_x[DIST_BITS-1:0];

	always_ff @(posedge clk) begin
		if (load_ok)
			mem[IW'(seg_index)] <= {end_z, end_y, end_x, start_z, start_y, start_x};
		if (state_q == T_READ) rd_q <= mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= COUNT_RESET;
			radius_q    <= RADIUS_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_SEGMENT_COUNT: seg_count_q <= pwdata[COUNT_BITS-1:0];
				REG_RADIUS_SQ:     radius_q    <= pwdata[RADIUS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SEGMENT_COUNT: prdata = APB_DATA_BITS'(seg_count_q);
			REG_RADIUS_SQ:     prdata = APB_DATA_BITS'(radius_q);
			default:           prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			idx_q       <= '0;
			n_q         <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == T_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (query_ok) begin
						idx_q   <= '0;
						n_q     <= n_eff;
						first_q <= 1'b1;
						state_q <= (n_eff == '0) ? T_DONE : T_READ;
					end
				end
				T_READ:  state_q <= T_START;
				T_START: state_q <= T_WAIT;
				T_WAIT: begin
					if (seg_done) begin
						first_q <= 1'b0;
						idx_q   <= idx_q + CW'(1);
						state_q <= ((idx_q + CW'(1)) == n_q) ? T_DONE : T_READ;
					end
				end
				T_DONE: begin
					// hold the result until the output register frees up
					if (out_free) state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (query_ok) begin
			point_q <= {point_z, point_y, point_x};
			best_q  <= '0;
		end
		if (state_q == T_WAIT && seg_done && (first_q || seg_dist < best_q))
			best_q <= seg_dist;
		if (state_q == T_DONE && out_free) begin
			min_q    <= best_sat;
			inside_q <= best_sat < DIST_BITS'(radius_q);
		end
	end

	ppd_seg_unit #(
		.COORD_BITS (COORD_BITS)
	) u_seg (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == T_START),
		.seg     (rd_q),
		.pt      (point_q),
		.done    (seg_done),
		.dist_sq (seg_dist)
	);

	assign out_valid   = out_valid_q;
	assign min_dist_sq = min_q;
	assign inside_res  = inside_q;

endmodule

// ===== hdl/ppd_seg_unit.sv =====
// ----------------------------------------------------------------------------
// ppd_seg_unit
// Squared distance from one point to one segment: three-lane dot products,
// a four-part wide multiplier and a restoring divider, all sequenced here.
// ----------------------------------------------------------------------------
module ppd_seg_unit #(
	parameter int COORD_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [6*COORD_BITS-1:0]   seg,
	input  logic [3*COORD_BITS-1:0]   pt,
	output logic                      done,
	output logic [2*COORD_BITS+2:0]   dist_sq
);
	localparam int C   = COORD_BITS;
	localparam int DW  = 2*C + 3;
	localparam int HW  = (DW + 1) / 2;
	localparam int AW  = 2*DW;
	localparam int DCW = $clog2(DW);

	localparam logic [1:0] DOT_TN = 2'd0;
	localparam logic [1:0] DOT_TD = 2'd1;
	localparam logic [1:0] DOT_DD = 2'd2;
	localparam logic [1:0] DOT_FF = 2'd3;

	typedef enum logic [5:0] {
		U_IDLE = 6'b000001,
		U_DOT  = 6'b000010,
		U_DEC  = 6'b000100,
		U_MUL  = 6'b001000,
		U_DLD  = 6'b010000,
		U_DIV  = 6'b100000
	} ustate_t;

	ustate_t                state_q;
	logic [3:0]             cnt_q;
	logic [DCW-1:0]         div_cnt_q;
	logic                   done_q;

	logic signed [C:0]      dir_q [3];
	logic signed [C:0]      d_q   [3];
	logic signed [C:0]      f_q   [3];
	logic signed [2*C+1:0]  prod_s1 [3];
	logic signed [DW-1:0]   dot_q [4];
	logic [2*HW-1:0]        pp_s1;
	logic [1:0]             sh_s1;
	logic                   sub_s1;
	logic [AW-1:0]          acc_q;
	logic [DW-1:0]          rem_q;
	logic [DW-1:0]          num_q;
	logic [DW-1:0]          dist_q;

	logic signed [C:0]      op_a [3];
	logic signed [C:0]      op_b [3];
	logic signed [DW-1:0]   lane_sum;
	logic signed [DW-1:0]   tn, td, dd, ff, ntn;
	logic [2*HW-1:0]        ua, ub;
	logic [HW-1:0]          a_h, b_h;
	logic [4*HW-1:0]        pp_wide;
	logic [DW:0]            div_t, div_d, div_diff;
	logic                   div_ge;
	logic [DW-1:0]          rem_next, num_next;

	assign tn  = dot_q[DOT_TN];
	assign td  = dot_q[DOT_TD];
	assign dd  = dot_q[DOT_DD];
	assign ff  = dot_q[DOT_FF];
	assign ntn = -tn;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			case (cnt_q[1:0])
				DOT_TN: begin op_a[k] = d_q[k];   op_b[k] = dir_q[k]; end
				DOT_TD: begin op_a[k] = dir_q[k]; op_b[k] = dir_q[k]; end
				DOT_DD: begin op_a[k] = d_q[k];   op_b[k] = d_q[k];   end
				default: begin op_a[k] = f_q[k];  op_b[k] = f_q[k];   end
			endcase
		end
	end

	assign lane_sum = DW'(prod_s1[0]) + DW'(prod_s1[1]) + DW'(prod_s1[2]);

	// first td*dd, then tn*tn taken away; all operands are nonnegative here
	assign ua  = cnt_q[2] ? (2*HW)'($unsigned(ntn)) : (2*HW)'($unsigned(td));
	assign ub  = cnt_q[2] ? (2*HW)'($unsigned(ntn)) : (2*HW)'($unsigned(dd));
	assign a_h = cnt_q[1] ? ua[2*HW-1:HW] : ua[HW-1:0];
	assign b_h = cnt_q[0] ? ub[2*HW-1:HW] : ub[HW-1:0];
	assign pp_wide = (4*HW)'(pp_s1) << (HW * sh_s1);

	assign div_t    = {rem_q, num_q[DW-1]};
	assign div_d    = {1'b0, $unsigned(td)};
	assign div_ge   = div_t >= div_d;
	assign div_diff = div_t - div_d;
	assign rem_next = div_ge ? div_diff[DW-1:0] : div_t[DW-1:0];
	assign num_next = {num_q[DW-2:0], div_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= U_IDLE;
			cnt_q     <= '0;
			div_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (start) begin
						cnt_q   <= '0;
						state_q <= U_DOT;
					end
				end
				U_DOT: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd4) state_q <= U_DEC;
				end
				U_DEC: begin
					if (!tn[DW-1] || ntn > td) begin
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end else begin
						cnt_q   <= '0;
						state_q <= U_MUL;
					end
				end
				U_MUL: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd8) state_q <= U_DLD;
				end
				U_DLD: begin
					div_cnt_q <= '0;
					state_q   <= U_DIV;
				end
				U_DIV: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(DW-1)) begin
						done_q  <= 1'b1;
						state_q <= U_IDLE;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			U_IDLE: begin
				if (start) begin
					for (int k = 0; k < 3; k++) begin
						dir_q[k] <= (C+1)'($signed(seg[(3+k)*C +: C]))
							- (C+1)'($signed(seg[k*C +: C]));
						d_q[k]   <= (C+1)'($signed(seg[k*C +: C]))
							- (C+1)'($signed(pt[k*C +: C]));
						f_q[k]   <= (C+1)'($signed(pt[k*C +: C]))
							- (C+1)'($signed(seg[(3+k)*C +: C]));
					end
				end
			end
			U_DOT: begin
				if (!cnt_q[2]) begin
					for (int k = 0; k < 3; k++) prod_s1[k] <= op_a[k] * op_b[k];
				end
				if (cnt_q != 4'd0) dot_q[cnt_q[1:0] - 2'd1] <= lane_sum;
			end
			U_DEC: begin
				acc_q <= '0;
				if (!tn[DW-1]) dist_q <= $unsigned(dd);
				else if (ntn > td) dist_q <= $unsigned(ff);
			end
			U_MUL: begin
				if (!cnt_q[3]) begin
					pp_s1  <= a_h * b_h;
					sh_s1  <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
					sub_s1 <= cnt_q[2];
				end
				if (cnt_q != 4'd0)
					acc_q <= sub_s1 ? acc_q - pp_wide[AW-1:0] : acc_q + pp_wide[AW-1:0];
			end
			U_DLD: begin
				// quotient fits DW bits, so the high half is already below td
				rem_q <= acc_q[AW-1:DW];
				num_q <= acc_q[DW-1:0];
			end
			U_DIV: begin
				rem_q <= rem_next;
				num_q <= num_next;
				if (div_cnt_q == DCW'(DW-1)) dist_q <= num_next;
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign dist_sq = dist_q;

endmodule

// ===== hdl/ppd_check.sv =====
// ----------------------------------------------------------------------------
// ppd_check
// Port-level checks for the point to polyline squared distance block.
// ----------------------------------------------------------------------------
module ppd_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            action,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [ppd_pkg::DIST_BITS-1:0]   min_dist_sq,
	input logic                            inside_res
);
	import ppd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(min_dist_sq))
		else $error("result word changed while stalled");

	a_load_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_LOAD |=> !in_stall)
		else $error("load word held the input");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action == ACT_QUERY |=> in_stall)
		else $error("query word did not hold the input");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word without a query in progress");

	a_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (min_dist_sq >> RADIUS_BITS) != '0 |-> !inside_res)
		else $error("inside flag set beyond any radius");

endmodule

bind point_polyline_distance_sq ppd_check u_ppd_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.action      (action),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.min_dist_sq (min_dist_sq),
	.inside_res  (inside_res)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the point to segment-table squared distance block. Segment loads and
// point queries go in through the input channel. Each query's minimum squared
// distance and inside flag are predicted from a local copy of the table and
// registers, then compared against the output word. Idle bursts and a long
// output hold-off exercise backpressure.
// ----------------------------------------------------------------------------
module testbench;
	import ppd_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam logic [191:0] SAT63 = {129'd0, {63{1'b1}}};

	typedef struct {
		logic                 act;
		logic [2:0]           idx;
		logic signed [CB-1:0] c [9];  // sx sy sz ex ey ez px py pz
	} word_t;

	typedef struct {
		logic [DIST_BITS-1:0] dist_sq;
		logic                 in_rad;
	} dist_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_LOAD;
	logic [SEG_INDEX_BITS-1:0] seg_index = '0;
	logic signed [CB-1:0] start_x = '0, start_y = '0, start_z = '0;
	logic signed [CB-1:0] end_x = '0, end_y = '0, end_z = '0;
	logic signed [CB-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [DIST_BITS-1:0] min_dist_sq;
	logic inside_res;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;

	logic signed [CB-1:0] seg_tbl [SEGMENTS_DEF][6];
	logic [COUNT_BITS-1:0] cur_count = COUNT_RESET;
	logic [RADIUS_BITS-1:0] cur_radius = RADIUS_RESET;
	dist_res_t dist_q [$];
	bit failed = 0;
	bit quiet = 0;
	int hold_req = 0;
	int hold_cnt = 0;
	int rx_gap = 0;

	point_polyline_distance_sq dut (.*);

	always #4 clk = ~clk;

	initial begin
		#20ms;
		$display("[point_polyline_distance_sq] ERROR");
		$finish;
	end

	function automatic logic [191:0] seg_dist_sq(input int s, input logic signed [CB-1:0] p [3]);
		logic signed [191:0] dir [3], d [3], f [3];
		logic signed [191:0] tn, td, cr, c;
		int a1, a2;
		tn = 0; td = 0; c = 0;
		for (int k = 0; k < 3; k++) begin
			dir[k] = 192'(seg_tbl[s][3+k]) - 192'(seg_tbl[s][k]);
			d[k] = 192'(seg_tbl[s][k]) - 192'(p[k]);
			f[k] = 192'(p[k]) - 192'(seg_tbl[s][3+k]);
			tn += d[k] * dir[k];
			td += dir[k] * dir[k];
		end
		if (tn >= 0)
			return d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
		if (-tn > td)
			return f[0]*f[0] + f[1]*f[1] + f[2]*f[2];
		for (int k = 0; k < 3; k++) begin
			a1 = (k + 1) % 3;
			a2 = (k + 2) % 3;
			cr = dir[a1] * d[a2] - dir[a2] * d[a1];
			c += cr * cr;
		end
		return c / td;
	endfunction

	function automatic dist_res_t predict_query(input logic signed [CB-1:0] p [3]);
		dist_res_t r;
		logic [191:0] best, cur;
		int n;
		n = (cur_count > SEGMENTS_DEF) ? SEGMENTS_DEF : cur_count;
		best = 0;
		for (int i = 0; i < n; i++) begin
			cur = seg_dist_sq(i, p);
			if (i == 0 || cur < best) best = cur;
		end
		if (best > SAT63) best = SAT63;
		r.dist_sq = best[DIST_BITS-1:0];
		r.in_rad = (best < 192'(cur_radius));
		return r;
	endfunction

	// receiver: check results and drive output stall
	always @(posedge clk) begin
		dist_res_t e;
		if (out_valid && !out_stall) begin
			if (dist_q.size() == 0) begin
				$error("unexpected result dist=%0d inside=%0b", min_dist_sq, inside_res);
				failed = 1;
			end else begin
				e = dist_q.pop_front();
				if (min_dist_sq !== e.dist_sq) begin
					$error("min_dist_sq expected %0d actual %0d", e.dist_sq, min_dist_sq);
					failed = 1;
				end
				if (inside_res !== e.in_rad) begin
					$error("inside_res expected %0b actual %0b", e.in_rad, inside_res);
					failed = 1;
				end
			end
		end
		if (hold_req > 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			rx_gap = $urandom_range(0, 9);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic send_word(input word_t w);
		logic signed [CB-1:0] p [3];
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= w.act;
		seg_index <= w.idx;
		start_x <= w.c[0]; start_y <= w.c[1]; start_z <= w.c[2];
		end_x <= w.c[3]; end_y <= w.c[4]; end_z <= w.c[5];
		point_x <= w.c[6]; point_y <= w.c[7]; point_z <= w.c[8];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (w.act == ACT_LOAD) begin
			for (int k = 0; k < 6; k++) seg_tbl[w.idx][k] = w.c[k];
		end else begin
			p = '{w.c[6], w.c[7], w.c[8]};
			dist_q.push_back(predict_query(p));
		end
	endtask

	// drop valid and let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (dist_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(input logic sel, input logic [31:0] v);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {sel, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (sel == REG_SEGMENT_COUNT) cur_count = v[COUNT_BITS-1:0];
		else cur_radius = v[RADIUS_BITS-1:0];
	endtask

	function automatic logic signed [CB-1:0] rand_coord(input bit full);
		if (full) return CB'($urandom);
		return CB'($signed($urandom_range(0, 127)) - 64);
	endfunction

	function automatic word_t load_word(input int idx, input int sx, sy, sz, ex, ey, ez);
		word_t w;
		w.act = ACT_LOAD; w.idx = 3'(idx);
		w.c = '{CB'(sx), CB'(sy), CB'(sz), CB'(ex), CB'(ey), CB'(ez), CB'(0), CB'(0), CB'(0)};
		return w;
	endfunction

	function automatic word_t query_word(input int px, py, pz);
		word_t w;
		w.act = ACT_QUERY; w.idx = 3'($urandom);
		for (int k = 0; k < 6; k++) w.c[k] = CB'($urandom);
		w.c[6] = CB'(px); w.c[7] = CB'(py); w.c[8] = CB'(pz);
		return w;
	endfunction

	function automatic word_t random_word(input int query_pct);
		word_t w;
		bit full;
		full = ($urandom_range(0, 2) == 0);
		w.act = ($urandom_range(0, 99) < query_pct) ? ACT_QUERY : ACT_LOAD;
		w.idx = 3'($urandom);
		for (int k = 0; k < 9; k++) w.c[k] = rand_coord(full);
		return w;
	endfunction

	task automatic test_directed();
		int mx, mn;
		mx = (1 << (CB - 1)) - 1;
		mn = -(1 << (CB - 1));
		// fill every slot before any query reaches it
		send_word(load_word(0, 0, 0, 0, 100, 0, 0));
		send_word(load_word(1, 5, 5, 5, 5, 5, 5));            // zero length
		send_word(load_word(2, mn, mn, mn, mx, mx, mx));
		send_word(load_word(3, mx, mn, mx, mn, mx, mn));
		send_word(load_word(4, -50, 20, 7, 30, -40, 9));
		send_word(load_word(5, mx, mx, mx, mx, mx, mx));
		send_word(load_word(6, mn, mn, mn, mn, mn, mn));
		send_word(load_word(7, 1, 2, 3, -3, -2, -1));
		send_word(query_word(50, 0, 0));                      // on a segment
		send_word(query_word(50, 3, 0));                      // interior projection
		send_word(query_word(-10, 0, 0));                     // before start
		send_word(query_word(200, 1, 1));                     // past end
		send_word(query_word(mx, mx, mx));
		send_word(query_word(mn, mn, mn));
		send_word(query_word(mx, mn, 0));
		wait_idle();
		reg_write(REG_SEGMENT_COUNT, 32'd0);
		reg_write(REG_RADIUS_SQ, 32'd0);
		send_word(query_word(1, 2, 3));
		wait_idle();
		reg_write(REG_SEGMENT_COUNT, 32'hFFFF_FFFF);          // saturates at table size
		reg_write(REG_RADIUS_SQ, 32'hABCD_FFFF);
		send_word(query_word(5, 5, 6));
		send_word(query_word(mn, mx, mn));
		wait_idle();
		reg_write(REG_SEGMENT_COUNT, 32'd1);
		reg_write(REG_RADIUS_SQ, 32'd100);
		send_word(query_word(50, 9, 0));
		send_word(query_word(50, 10, 0));
		wait_idle();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			reg_write(REG_SEGMENT_COUNT, (ph == 5) ? 32'd8 : $urandom_range(0, 4) + 32'($urandom) * 16);
			reg_write(REG_RADIUS_SQ, (ph == 0) ? 32'd65535 : $urandom);
			repeat (150) send_word(random_word(40));
			wait_idle();
		end
	endtask

	task automatic test_backpressure();
		reg_write(REG_SEGMENT_COUNT, 32'd2);
		reg_write(REG_RADIUS_SQ, 32'd4000);
		hold_req = 600;
		repeat (16) send_word(random_word(60));
		wait_idle();
	endtask

	task automatic test_streaming();
		quiet = 1;
		reg_write(REG_SEGMENT_COUNT, 32'd3);
		repeat (120) send_word(random_word(40));
		wait_idle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_streaming();
		repeat (50) @(posedge clk);
		if (!failed) begin
			$display("[point_polyline_distance_sq] OK");
		end else begin
			$display("[point_polyline_distance_sq] ERROR");
		end
		$finish;
	end

endmodule
